[rtl/sts_pkg.sv]
// Shared types, token kinds and operator tables of the source token scanner.
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;

  localparam int POSITION_BITS_DEF = 20;
  localparam int POS_W   = 20;
  localparam int KIND_W  = 6;
  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 8;
  localparam int TDATA_W = 120;

  localparam logic [KIND_W-1:0] K_EOF     = 6'd0;
  localparam logic [KIND_W-1:0] K_UNKNOWN = 6'd1;
  localparam logic [KIND_W-1:0] K_ID      = 6'd3;
  localparam logic [KIND_W-1:0] K_TYPEID  = 6'd4;
  localparam logic [KIND_W-1:0] K_INTEGER = 6'd5;
  localparam logic [KIND_W-1:0] K_CHARS   = 6'd46;
  localparam logic [KIND_W-1:0] K_STRING  = 6'd47;
  localparam logic [KIND_W-1:0] K_NONE    = 6'd0;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 64'd1844674407370955161;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_OPER    = 4'd1,
    MODE_WORD    = 4'd2,
    MODE_DOLLAR  = 4'd3,
    MODE_AT      = 4'd4,
    MODE_NUMBER  = 4'd5,
    MODE_CHARLIT = 4'd6,
    MODE_STRLIT  = 4'd7
  } mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  unknown_char;
    logic               number_bad;
    logic [VALUE_W-1:0] number_value;
    logic [POS_W-1:0]   text_length;
    logic [POS_W-1:0]   start_offset;
    logic [KIND_W-1:0]  kind;
  } res_t;

  function automatic res_t make_res(logic [KIND_W-1:0] kind, logic [POS_W-1:0] start,
                                    logic [POS_W-1:0] len, logic [VALUE_W-1:0] value,
                                    logic bad, logic [CHAR_W-1:0] unk);
    res_t r;
    r.kind         = kind;
    r.start_offset = start;
    r.text_length  = len;
    r.number_value = value;
    r.number_bad   = bad;
    r.unknown_char = unk;
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    k = K_NONE;
    unique case (c)
      "(": k = 6'd6;   ")": k = 6'd7;   "[": k = 6'd8;
      "]": k = 6'd9;   "{": k = 6'd10;  "}": k = 6'd11;
      ";": k = 6'd12;  "+": k = 6'd13;  "-": k = 6'd14;
      "*": k = 6'd15;  "/": k = 6'd16;  "%": k = 6'd17;
      "&": k = 6'd18;  "|": k = 6'd19;  "^": k = 6'd20;
      "!": k = 6'd21;  "?": k = 6'd22;  ":": k = 6'd23;
      "=": k = 6'd24;  "<": k = 6'd37;  ">": k = 6'd38;
      "~": k = 6'd43;  ".": k = 6'd44;  ",": k = 6'd45;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] pair_kind(logic [CHAR_W-1:0] a,
                                                  logic [CHAR_W-1:0] b);
    logic [KIND_W-1:0] k;
    k = K_NONE;
    if (b == "=") begin
      unique case (a)
        "+": k = 6'd25;  "-": k = 6'd26;  "*": k = 6'd27;
        "/": k = 6'd28;  "%": k = 6'd29;  "&": k = 6'd30;
        "|": k = 6'd31;  "^": k = 6'd32;  "=": k = 6'd35;
        "!": k = 6'd36;  "<": k = 6'd39;  ">": k = 6'd40;
        default: k = K_NONE;
      endcase
    end else if (a == b) begin
      unique case (a)
        "+": k = 6'd33;  "-": k = 6'd34;
        "&": k = 6'd41;  "|": k = 6'd42;
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

endpackage
`default_nettype wire

[rtl/source_token_scanner.sv]
// Top level of the source token scanner: byte-wise scanner and two-slot result buffer.
// The scanner takes one source byte per request and updates its state in the same cycle,
// so a byte is accepted every cycle while the result buffer has room. A byte that
// closes one token and emits another (or the end marker after a pending token) queues two
// results; the two-slot output buffer then holds input until the first of them is taken.
// The first result of an accepted request is registered and offered in the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module source_token_scanner #(
  parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire  [7:0]                 in_tdata,   // [7:0] ch
  input  wire                        in_tuser,   // [0] end_of_input
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [sts_pkg::TDATA_W-1:0] out_tdata, // kind, start_offset, text_length,
                                                 // number_value, number_bad, unknown_char
  output logic                       out_tlast
);

  localparam int PW = POSITION_BITS;
  localparam logic [PW-1:0] LEN_MAX = {PW{1'b1}};

  sts_pkg::mode_t             mode_r, mode_nxt;
  logic [7:0]                 op_r, op_nxt;
  logic [PW-1:0]              start_r, start_nxt;
  logic [PW-1:0]              len_r, len_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [63:0]                acc_r, acc_nxt;
  logic                       escp_r, escp_nxt;
  logic                       lower_r, lower_nxt;
  logic                       upper_r, upper_nxt;
  logic                       nerr_r, nerr_nxt;

  sts_pkg::res_t              q0_r, q1_r, res0, res1;
  logic                       l0_r, l1_r;
  logic [1:0]                 cnt_r, n;
  logic                       in_acc, out_acc;

  function automatic logic [sts_pkg::POS_W-1:0] fit(logic [PW-1:0] v);
    logic [sts_pkg::POS_W+PW-1:0] w;
    w = (sts_pkg::POS_W+PW)'(v);
    return w[sts_pkg::POS_W-1:0];
  endfunction

  assign in_tready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = cnt_r != 2'd0;
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {1'b0, q0_r};
  assign out_tlast  = l0_r;

  always_comb begin
    logic [7:0]                 c;
    logic [PW-1:0]              len_g;
    logic                       done, fl_v, is_up, is_lo, is_dg, is_al, is_sp;
    sts_pkg::res_t              fl, tk;
    logic [sts_pkg::KIND_W-1:0] pk, sk;
    logic [63:0]                d;
    c         = in_tdata;
    mode_nxt  = mode_r;  op_nxt = op_r;  start_nxt = start_r;  len_nxt = len_r;
    pos_nxt   = pos_r;   acc_nxt = acc_r; escp_nxt = escp_r;   lower_nxt = lower_r;
    upper_nxt = upper_r; nerr_nxt = nerr_r;
    res0 = '0; res1 = '0; n = 2'd0; done = 1'b0; tk = '0;
    is_up = (c >= "A") && (c <= "Z");
    is_lo = (c >= "a") && (c <= "z");
    is_dg = (c >= "0") && (c <= "9");
    is_al = is_up || is_lo;
    is_sp = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    len_g = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
    pk    = sts_pkg::pair_kind(op_r, c);
    sk    = sts_pkg::single_kind(c);
    d     = 64'(c - "0");

    // Token held by the current mode, if any.
    fl_v = 1'b1;
    fl   = '0;
    unique case (mode_r)
      sts_pkg::MODE_OPER:
        fl = sts_pkg::make_res(sts_pkg::single_kind(op_r), fit(start_r), 20'd1, '0, 1'b0,
                               '0);
      sts_pkg::MODE_WORD:
        fl = sts_pkg::make_res((upper_r && (len_r <= 1 || lower_r)) ? sts_pkg::K_TYPEID
                               : sts_pkg::K_ID, fit(start_r), fit(len_r), '0, 1'b0, '0);
      sts_pkg::MODE_DOLLAR:
        fl = sts_pkg::make_res(sts_pkg::K_ID, fit(start_r), fit(len_r), '0, 1'b0, '0);
      sts_pkg::MODE_AT:
        fl = sts_pkg::make_res(sts_pkg::K_TYPEID, fit(start_r), fit(len_r), '0, 1'b0, '0);
      sts_pkg::MODE_NUMBER:
        fl = sts_pkg::make_res(sts_pkg::K_INTEGER, fit(start_r), fit(len_r),
                               nerr_r ? '0 : acc_r, nerr_r, '0);
      sts_pkg::MODE_CHARLIT:
        fl = sts_pkg::make_res(sts_pkg::K_CHARS, fit(start_r), fit(len_r), '0, 1'b0, '0);
      sts_pkg::MODE_STRLIT:
        fl = sts_pkg::make_res(sts_pkg::K_STRING, fit(start_r), fit(len_r), '0, 1'b0, '0);
      default: fl_v = 1'b0;
    endcase

    if (in_tuser) begin
      tk = sts_pkg::make_res(sts_pkg::K_EOF, fit(pos_r), '0, '0, 1'b0, '0);
      if (fl_v) begin
        res0 = fl; res1 = tk; n = 2'd2;
      end else begin
        res0 = tk; n = 2'd1;
      end
      mode_nxt = sts_pkg::MODE_IDLE; op_nxt = '0; start_nxt = '0; len_nxt = '0;
      pos_nxt = '0; acc_nxt = '0; escp_nxt = 1'b0; lower_nxt = 1'b0; upper_nxt = 1'b0;
      nerr_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        sts_pkg::MODE_OPER: begin
          mode_nxt = sts_pkg::MODE_IDLE;
          if (pk != sts_pkg::K_NONE) begin
            res0 = sts_pkg::make_res(pk, fit(start_r), 20'd2, '0, 1'b0, '0);
            n = 2'd1; done = 1'b1;
          end else begin
            res0 = fl; n = 2'd1;
          end
        end
        sts_pkg::MODE_WORD, sts_pkg::MODE_DOLLAR, sts_pkg::MODE_AT: begin
          if (is_al || is_dg || c == "_") begin
            len_nxt = len_g;
            if (is_lo) lower_nxt = 1'b1;
            done = 1'b1;
          end else begin
            res0 = fl; n = 2'd1; mode_nxt = sts_pkg::MODE_IDLE;
          end
        end
        sts_pkg::MODE_NUMBER: begin
          if (is_al || is_dg) begin
            len_nxt = len_g;
            if (is_dg) begin
              if (acc_r > sts_pkg::VALUE_LIMIT ||
                  (acc_r == sts_pkg::VALUE_LIMIT && d > 64'd5)) nerr_nxt = 1'b1;
              // Times ten as two shifted copies.
              acc_nxt = (acc_r << 3) + (acc_r << 1) + d;
            end else begin
              nerr_nxt = 1'b1;
            end
            done = 1'b1;
          end else begin
            res0 = fl; n = 2'd1; mode_nxt = sts_pkg::MODE_IDLE;
          end
        end
        sts_pkg::MODE_CHARLIT, sts_pkg::MODE_STRLIT: begin
          done = 1'b1;
          if (escp_r) begin
            escp_nxt = 1'b0; len_nxt = len_g;
          end else if (c == "\\") begin
            escp_nxt = 1'b1; len_nxt = len_g;
          end else if (c == ((mode_r == sts_pkg::MODE_CHARLIT) ? 8'h27 : 8'h22)) begin
            res0 = fl; n = 2'd1; mode_nxt = sts_pkg::MODE_IDLE;
          end else begin
            len_nxt = len_g;
          end
        end
        default: ;
      endcase

      if (!done && !is_sp) begin
        start_nxt = pos_r;
        len_nxt   = '0;
        tk        = '0;
        if (sts_pkg::pair_kind(c, "=") != sts_pkg::K_NONE) begin
          mode_nxt = sts_pkg::MODE_OPER; op_nxt = c;
        end else if (sk != sts_pkg::K_NONE) begin
          tk = sts_pkg::make_res(sk, fit(pos_r), 20'd1, '0, 1'b0, '0);
        end else if (c == 8'h27 || c == 8'h22 || c == "$" || c == "@") begin
          start_nxt = pos_r + 1'b1;
          escp_nxt  = 1'b0;
          mode_nxt  = (c == 8'h27) ? sts_pkg::MODE_CHARLIT :
                      (c == 8'h22) ? sts_pkg::MODE_STRLIT :
                      (c == "$")   ? sts_pkg::MODE_DOLLAR : sts_pkg::MODE_AT;
          lower_nxt = 1'b0; upper_nxt = 1'b0;
        end else if (is_al) begin
          mode_nxt = sts_pkg::MODE_WORD; len_nxt = PW'(1);
          upper_nxt = is_up; lower_nxt = 1'b0;
        end else if (is_dg) begin
          mode_nxt = sts_pkg::MODE_NUMBER; len_nxt = PW'(1);
          acc_nxt = d; nerr_nxt = 1'b0;
        end else begin
          tk = sts_pkg::make_res(sts_pkg::K_UNKNOWN, fit(pos_r), 20'd1, '0, 1'b0, c);
        end
        if (tk != '0) begin
          if (n == 2'd0) res0 = tk;
          else res1 = tk;
          n = n + 2'd1;
        end
      end
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sts_pkg::MODE_IDLE; op_r <= '0; start_r <= '0; len_r <= '0; pos_r <= '0;
      acc_r <= '0; escp_r <= 1'b0; lower_r <= 1'b0; upper_r <= 1'b0; nerr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt; op_r <= op_nxt; start_r <= start_nxt; len_r <= len_nxt;
        pos_r <= pos_nxt; acc_r <= acc_nxt; escp_r <= escp_nxt; lower_r <= lower_nxt;
        upper_r <= upper_nxt; nerr_r <= nerr_nxt;
        cnt_r <= n;
      end else if (out_acc) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q0_r <= res0; q1_r <= res1;
      l0_r <= (n == 2'd1); l1_r <= 1'b1;
    end else if (out_acc) begin
      q0_r <= q1_r; l0_r <= l1_r;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("result buffer count out of range");
  a_eof_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> out_tvalid && pos_r == '0 && mode_r == sts_pkg::MODE_IDLE)
    else $error("end marker did not give a result and clear state");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> cnt_r == 2'd0 || out_acc)
    else $error("request taken while results still queued");
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !out_tlast)
    else $error("first of two results marked last");

endmodule
`default_nettype wire

[tb/sv/source_token_scanner_test.sv]
// Self-checking testbench of the source token scanner with a built-in token predictor.
`timescale 1ns / 1ps
module source_token_scanner_test;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  typedef struct packed {
    logic           tlast;
    sts_pkg::res_t  tok;
  } token_t;

  localparam int POS_MAX = (1 << sts_pkg::POS_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sts_pkg::TDATA_W-1:0] out_tdata;
  logic out_tlast;

  source_token_scanner uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  src_byte_t pending_bytes[$];
  token_t    expected_tokens[$];
  int  mismatches = 0;
  bit  stimulus_done = 1'b0;
  bit  hold_off = 1'b0;
  bit  drain_pause = 1'b0;

  // Scanner state of the predictor.
  sts_pkg::mode_t sc_mode;
  logic [7:0]  sc_oper;
  logic [19:0] sc_start, sc_len, sc_pos;
  logic [63:0] sc_acc;
  logic        sc_escape, sc_lower, sc_upper, sc_bad;

  function automatic bit is_up(logic [7:0] c);  return c >= "A" && c <= "Z"; endfunction
  function automatic bit is_lo(logic [7:0] c);  return c >= "a" && c <= "z"; endfunction
  function automatic bit is_dig(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
  function automatic bit is_ws(logic [7:0] c);  return c == " " || (c >= 9 && c <= 13); endfunction

  // Kinds of operators, written out independently of the package tables.
  function automatic logic [5:0] lone_op_kind(logic [7:0] c);
    string ops;
    ops = "()[]{};+-*/%&|^!?:=";
    for (int i = 0; i < ops.len(); i++)
      if (ops[i] == c) return 6'(6 + i);
    case (c)
      "<": return 6'd37;
      ">": return 6'd38;
      "~": return 6'd43;
      ".": return 6'd44;
      ",": return 6'd45;
      default: return sts_pkg::K_NONE;
    endcase
  endfunction

  function automatic logic [5:0] two_op_kind(logic [7:0] a, logic [7:0] b);
    if (b == "=") begin
      case (a)
        "+": return 6'd25; "-": return 6'd26; "*": return 6'd27; "/": return 6'd28;
        "%": return 6'd29; "&": return 6'd30; "|": return 6'd31; "^": return 6'd32;
        "=": return 6'd35; "!": return 6'd36; "<": return 6'd39; ">": return 6'd40;
        default: return sts_pkg::K_NONE;
      endcase
    end
    if (a == b) begin
      case (a)
        "+": return 6'd33; "-": return 6'd34; "&": return 6'd41; "|": return 6'd42;
        default: return sts_pkg::K_NONE;
      endcase
    end
    return sts_pkg::K_NONE;
  endfunction

  task automatic clear_scanner();
    sc_mode = sts_pkg::MODE_IDLE; sc_oper = 0; sc_start = 0; sc_len = 0; sc_pos = 0;
    sc_acc = 0; sc_escape = 0; sc_lower = 0; sc_upper = 0; sc_bad = 0;
  endtask

  task automatic emit(ref token_t toks[$], input logic [5:0] k, input logic [19:0] st,
                      input logic [19:0] ln, input logic [63:0] v, input logic b,
                      input logic [7:0] u);
    token_t t;
    t.tlast = 1'b0;
    t.tok.kind = k; t.tok.start_offset = st; t.tok.text_length = ln;
    t.tok.number_value = v; t.tok.number_bad = b; t.tok.unknown_char = u;
    toks.push_back(t);
  endtask

  task automatic lengthen();
    if (sc_len != 20'(POS_MAX)) sc_len++;
  endtask

  task automatic close_token(ref token_t toks[$]);
    logic [5:0] k;
    case (sc_mode)
      sts_pkg::MODE_OPER: emit(toks, lone_op_kind(sc_oper), sc_start, 1, 0, 0, 0);
      sts_pkg::MODE_WORD: begin
        k = (sc_upper && (sc_len <= 1 || sc_lower)) ? sts_pkg::K_TYPEID : sts_pkg::K_ID;
        emit(toks, k, sc_start, sc_len, 0, 0, 0);
      end
      sts_pkg::MODE_DOLLAR:  emit(toks, sts_pkg::K_ID, sc_start, sc_len, 0, 0, 0);
      sts_pkg::MODE_AT:      emit(toks, sts_pkg::K_TYPEID, sc_start, sc_len, 0, 0, 0);
      sts_pkg::MODE_NUMBER:
        emit(toks, sts_pkg::K_INTEGER, sc_start, sc_len, sc_bad ? 64'd0 : sc_acc, sc_bad, 0);
      sts_pkg::MODE_CHARLIT: emit(toks, sts_pkg::K_CHARS, sc_start, sc_len, 0, 0, 0);
      sts_pkg::MODE_STRLIT:  emit(toks, sts_pkg::K_STRING, sc_start, sc_len, 0, 0, 0);
      default: ;
    endcase
    sc_mode = sts_pkg::MODE_IDLE;
  endtask

  // Works out the tokens that one source byte closes or opens.
  task automatic scan_byte(input src_byte_t b);
    token_t toks[$];
    logic [7:0]  c;
    logic [19:0] p;
    logic [5:0]  k;
    logic [63:0] d;
    bit consumed;
    c = b.ch; p = sc_pos; consumed = 0;
    if (b.eoi) begin
      close_token(toks);
      emit(toks, sts_pkg::K_EOF, p, 0, 0, 0, 0);
      clear_scanner();
    end else begin
      case (sc_mode)
        sts_pkg::MODE_OPER: begin
          k = two_op_kind(sc_oper, c);
          if (k != sts_pkg::K_NONE) begin
            emit(toks, k, sc_start, 2, 0, 0, 0);
            sc_mode = sts_pkg::MODE_IDLE;
            consumed = 1;
          end else close_token(toks);
        end
        sts_pkg::MODE_WORD, sts_pkg::MODE_DOLLAR, sts_pkg::MODE_AT: begin
          if (is_up(c) || is_lo(c) || is_dig(c) || c == "_") begin
            lengthen();
            if (is_lo(c)) sc_lower = 1;
            consumed = 1;
          end else close_token(toks);
        end
        sts_pkg::MODE_NUMBER: begin
          if (is_up(c) || is_lo(c) || is_dig(c)) begin
            lengthen();
            if (is_dig(c)) begin
              d = 64'(c - "0");
              if (sc_acc > sts_pkg::VALUE_LIMIT ||
                  (sc_acc == sts_pkg::VALUE_LIMIT && d > 5)) sc_bad = 1;
              sc_acc = sc_acc * 10 + d;
            end else sc_bad = 1;
            consumed = 1;
          end else close_token(toks);
        end
        sts_pkg::MODE_CHARLIT, sts_pkg::MODE_STRLIT: begin
          consumed = 1;
          if (sc_escape) begin
            sc_escape = 0; lengthen();
          end else if (c == "\\") begin
            sc_escape = 1; lengthen();
          end else if (c == ((sc_mode == sts_pkg::MODE_CHARLIT) ? 8'h27 : 8'h22)) begin
            close_token(toks);
          end else lengthen();
        end
        default: ;
      endcase
      if (!consumed && !is_ws(c)) begin
        sc_start = p; sc_len = 0;
        if (two_op_kind(c, "=") != sts_pkg::K_NONE) begin
          sc_mode = sts_pkg::MODE_OPER; sc_oper = c;
        end else if (lone_op_kind(c) != sts_pkg::K_NONE) begin
          emit(toks, lone_op_kind(c), p, 1, 0, 0, 0);
        end else if (c == 8'h27 || c == 8'h22 || c == "$" || c == "@") begin
          sc_start = p + 1;
          sc_escape = 0; sc_lower = 0; sc_upper = 0;
          sc_mode = (c == 8'h27) ? sts_pkg::MODE_CHARLIT :
                    (c == 8'h22) ? sts_pkg::MODE_STRLIT :
                    (c == "$") ? sts_pkg::MODE_DOLLAR : sts_pkg::MODE_AT;
        end else if (is_up(c) || is_lo(c)) begin
          sc_mode = sts_pkg::MODE_WORD; sc_len = 1; sc_upper = is_up(c); sc_lower = 0;
        end else if (is_dig(c)) begin
          sc_mode = sts_pkg::MODE_NUMBER; sc_len = 1; sc_acc = 64'(c - "0"); sc_bad = 0;
        end else begin
          emit(toks, sts_pkg::K_UNKNOWN, p, 1, 0, 0, c);
        end
      end
      sc_pos = p + 1;
    end
    if (toks.size() > 0) toks[toks.size()-1].tlast = 1'b1;
    foreach (toks[i]) expected_tokens.push_back(toks[i]);
  endtask

  // A request taken at a rising edge goes to the predictor at that edge.
  bit in_taken = 1'b0;
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      scan_byte('{ch: in_tdata, eoi: in_tuser});
      in_taken = 1'b1;
    end
  end

  // Driver: one request per item, with a random gap before each.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (drain_pause && expected_tokens.size() != 0) begin
          in_tvalid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          src_byte_t b;
          b = pending_bytes.pop_front();
          in_tdata <= b.ch;
          in_tuser <= b.eoi;
          in_tvalid <= 1'b1;
          send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern.
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    end
  end

  // Monitor: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      token_t got, want;
      got.tok = out_tdata[$bits(sts_pkg::res_t)-1:0];
      got.tlast = out_tlast;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token: %p", got);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("token mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic add_text(string s);
    foreach (s[i]) pending_bytes.push_back('{ch: s[i], eoi: 1'b0});
  endtask

  task automatic add_end();
    pending_bytes.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
  endtask

  task automatic wait_sent();
    while (pending_bytes.size() > 0 || in_tvalid) @(posedge clk);
  endtask

  // Random source fragment that is mostly well-formed tokens.
  task automatic add_random_fragment();
    string alpha, ops;
    int n;
    alpha = "abcxyzABCXYZ_09";
    ops = "()[]{};+-*/%&|^!?:=<>~.,";
    case ($urandom_range(0, 11))
      0: begin
        pending_bytes.push_back('{ch: 8'($urandom_range(65, 90)), eoi: 1'b0});
        n = $urandom_range(0, 5);
        repeat (n) pending_bytes.push_back('{ch: 8'(alpha[$urandom_range(0, 14)]), eoi: 1'b0});
      end
      1: begin
        n = $urandom_range(1, 22);
        repeat (n) pending_bytes.push_back('{ch: 8'($urandom_range(48, 57)), eoi: 1'b0});
        if ($urandom_range(0, 4) == 0) add_text("q");
      end
      2, 3: begin
        pending_bytes.push_back('{ch: 8'(ops[$urandom_range(0, 23)]), eoi: 1'b0});
        if ($urandom_range(0, 1)) pending_bytes.push_back(
          '{ch: 8'(($urandom_range(0, 1)) ? "=" : ops[$urandom_range(0, 23)]), eoi: 1'b0});
      end
      4: begin
        add_text($urandom_range(0, 1) ? "\"" : "'");
        n = $urandom_range(0, 6);
        repeat (n) pending_bytes.push_back('{ch: 8'($urandom_range(32, 126)), eoi: 1'b0});
        add_text($urandom_range(0, 1) ? "\"" : "'");
      end
      5: begin
        add_text($urandom_range(0, 1) ? "$" : "@");
        n = $urandom_range(0, 4);
        repeat (n) pending_bytes.push_back('{ch: 8'(alpha[$urandom_range(0, 14)]), eoi: 1'b0});
      end
      6, 7: add_text(" ");
      8: pending_bytes.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b0});
      9: begin
        n = $urandom_range(1, 4);
        repeat (n) pending_bytes.push_back('{ch: 8'($urandom_range(97, 122)), eoi: 1'b0});
      end
      10: add_text("\n\t");
      default: if ($urandom_range(0, 9) == 0) add_end(); else add_text(" ");
    endcase
  endtask

  initial begin
    clear_scanner();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: operators, pairs, literals with escapes, case rules, overflow, bad numbers.
    add_text("a+=b++ X XY Xy $ @T 'a\\'' \"s\\\" 18446744073709551616 12ab _\\");
    pending_bytes.push_back('{ch: 8'hFF, eoi: 1'b0});
    pending_bytes.push_back('{ch: 8'h80, eoi: 1'b0});
    add_text("\"open");
    add_end();
    add_text("18446744073709551615 -");
    add_end();
    add_end();
    wait_sent();
    // The receiver holds off while the sender keeps offering requests.
    hold_off = 1'b1;
    repeat (40) add_random_fragment();
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
    wait_sent();
    drain_pause = 1'b1;
    add_text("== !=");
    wait_sent();
    drain_pause = 1'b0;
    while (pending_bytes.size() < 530) add_random_fragment();
    add_text("Zz");
    add_end();
    wait_sent();
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
